// ===== sv/tagged_object_slot_store_macros.svh =====
// Assertion macros shared by the slot store modules.
// Expects signals clk and arst_n in the scope of each use.
`ifndef TAGGED_OBJECT_SLOT_STORE_MACROS_SVH
`define TAGGED_OBJECT_SLOT_STORE_MACROS_SVH
`ifndef SYNTHESIS
`define TOS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TOS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TOS_ASSERT(lbl, prop, msg)
`define TOS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/tos_pkg.sv =====
// Package of the tagged object slot store: sizes, codes, payload and control types.
// No dependencies.
package tos_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int MAX_LEN   = 256;

	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int LEN_W     = $clog2(MAX_LEN + 1);
	localparam int MEM_DEPTH = NUM_SLOTS * MAX_LEN;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam int KIND_W    = 2;
	localparam int TAG_W     = 16;
	localparam int PLEN_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int OFF_W     = 8;
	localparam int STATUS_W  = 2;
	localparam int OUT_LEN_W = 9;

	localparam logic [KIND_W-1:0] KIND_PUT   = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_GET   = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_CLEAR = KIND_W'(2);

	localparam logic [STATUS_W-1:0] STATUS_OK        = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = STATUS_W'(2);
	localparam logic [STATUS_W-1:0] STATUS_FULL      = STATUS_W'(3);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TAG_W-1:0]  tag;
		logic [PLEN_W-1:0] put_length;
		logic [BYTE_W-1:0] data_in;
		logic              last_byte;
		logic [OFF_W-1:0]  read_offset;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [OUT_LEN_W-1:0] stored_length;
		logic [BYTE_W-1:0]    data_out;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic res_needed;
	} dp_stat_t;

endpackage

// ===== sv/tos_req_if.sv =====
// Request channel interface of the slot store.
// Depends on tos_pkg.
interface tos_req_if import tos_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tos_rsp_if.sv =====
// Result channel interface of the slot store.
// Depends on tos_pkg.
interface tos_rsp_if import tos_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tos_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tos_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 256,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== sv/tos_ctrl.sv =====
// Controller of the slot store: input acceptance and result handoff.
// Depends on tos_pkg and the assertion macro header.
`include "tagged_object_slot_store_macros.svh"
module tos_ctrl import tos_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd,
	output logic      in_ready,
	output logic      out_valid
);
	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.load_out = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && stat.res_needed) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				// pending result moves once the output register frees up
				cmd.load_out = !out_valid_q || out_ready;
				if (cmd.load_out) begin
					state_d = ST_IDLE;
				end
			end
		endcase
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

	`TOS_ASSERT(a_result_goes_pending, cmd.accept && stat.res_needed |=> state_q == ST_RESULT, "result item did not go pending")
	`TOS_ASSERT(a_load_fills_out, cmd.load_out |=> out_valid_q, "output register not loaded")
	`TOS_ASSERT_NEVER(a_load_over_full, cmd.load_out && out_valid_q && !out_ready, "output overwritten")
endmodule

// ===== sv/tos_datapath.sv =====
// Datapath of the slot store: slot table, tag lookup, put run state,
// byte memory, pending result and output register. Depends on tos_pkg,
// tos_ram and the assertion macro header.
`include "tagged_object_slot_store_macros.svh"
module tos_datapath import tos_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	input  req_t      req_data,
	output dp_stat_t  stat,
	output rsp_t      rsp_data
);
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0]    length;
		logic                rd_ok;
	} res_t;

	function automatic logic [MEM_AW-1:0] byte_addr(input logic [SLOT_W-1:0] s,
		input logic [LEN_W-1:0] i);
		return MEM_AW'(MEM_AW'(s) * MEM_AW'(MAX_LEN) + MEM_AW'(i));
	endfunction

	// slot table
	logic [NUM_SLOTS-1:0] valid_q;
	logic [TAG_W-1:0]     tag_q [NUM_SLOTS];
	logic [LEN_W-1:0]     len_q [NUM_SLOTS];

	// put run
	logic                put_active_q;
	logic [SLOT_W-1:0]   put_slot_q;
	logic [LEN_W-1:0]    put_idx_q;
	logic [STATUS_W-1:0] put_err_q;
	logic [LEN_W-1:0]    put_decl_q;
	logic [TAG_W-1:0]    put_tag_q;

	res_t res_s1, res_next;
	rsp_t rsp_q;

	logic [NUM_SLOTS-1:0] hit_vec;
	logic                 hit_any, free_any;
	logic [SLOT_W-1:0]    hit_idx, free_idx;
	logic [LEN_W-1:0]     hit_len;

	logic                is_put, is_get, is_clear, first, put_close;
	logic [STATUS_W-1:0] first_err, eff_err;
	logic [SLOT_W-1:0]   first_slot, eff_slot;
	logic [LEN_W-1:0]    eff_idx, eff_decl, idx_next;
	logic [TAG_W-1:0]    eff_tag;
	logic                do_write, get_rd_ok;

	logic              ram_we, ram_re;
	logic [MEM_AW-1:0] ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	// parallel tag match, lowest index wins
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			hit_vec[i] = valid_q[i] && (tag_q[i] == req_data.tag);
		end
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
		hit_any  = |hit_vec;
		free_any = ~&valid_q;
	end

	assign hit_len = len_q[hit_idx];

	always_comb begin
		is_put   = (req_data.kind == KIND_PUT);
		is_get   = (req_data.kind == KIND_GET);
		is_clear = (req_data.kind == KIND_CLEAR);
		first    = !put_active_q;

		if (int'(req_data.put_length) > MAX_LEN) begin
			first_err = STATUS_TOO_LONG;
		end else if (!hit_any && !free_any) begin
			first_err = STATUS_FULL;
		end else begin
			first_err = STATUS_OK;
		end
		first_slot = hit_any ? hit_idx : free_idx;

		eff_err  = first ? first_err : put_err_q;
		eff_slot = first ? first_slot : put_slot_q;
		eff_idx  = first ? '0 : put_idx_q;
		eff_decl = first ? LEN_W'(req_data.put_length) : put_decl_q;
		eff_tag  = first ? req_data.tag : put_tag_q;

		// bytes past the declared length are dropped
		do_write  = is_put && (eff_err == STATUS_OK) && (eff_idx < eff_decl);
		idx_next  = eff_idx + LEN_W'(do_write);
		put_close = req_data.last_byte || (first && (req_data.put_length == '0));

		get_rd_ok = hit_any && (int'(req_data.read_offset) < int'(hit_len))
			&& (int'(req_data.read_offset) < MAX_LEN);

		stat.res_needed = is_get || is_clear || (is_put && put_close);

		res_next.status = STATUS_OK;
		res_next.length = '0;
		res_next.rd_ok  = 1'b0;
		if (is_get) begin
			res_next.status = hit_any ? STATUS_OK : STATUS_NOT_FOUND;
			res_next.length = hit_any ? hit_len : '0;
			res_next.rd_ok  = get_rd_ok;
		end else if (is_put) begin
			res_next.status = eff_err;
		end
	end

	assign ram_we    = cmd.accept && do_write;
	assign ram_waddr = byte_addr(eff_slot, eff_idx);
	assign ram_re    = cmd.accept && is_get;
	assign ram_raddr = byte_addr(hit_idx, LEN_W'(req_data.read_offset));

	tos_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req_data.data_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			put_active_q <= 1'b0;
			put_slot_q   <= '0;
			put_idx_q    <= '0;
			put_err_q    <= STATUS_OK;
		end else if (cmd.accept) begin
			if (is_clear) begin
				valid_q      <= '0;
				put_active_q <= 1'b0;
				put_idx_q    <= '0;
				put_err_q    <= STATUS_OK;
			end else if (is_put) begin
				if (put_close && (eff_err == STATUS_OK)) begin
					valid_q[eff_slot] <= 1'b1;
				end else if (first && (first_err == STATUS_OK)) begin
					// replacing an object hides it for the whole run
					valid_q[first_slot] <= 1'b0;
				end
				if (put_close) begin
					put_active_q <= 1'b0;
					put_idx_q    <= '0;
					put_err_q    <= STATUS_OK;
				end else begin
					put_active_q <= 1'b1;
					put_idx_q    <= idx_next;
					put_err_q    <= eff_err;
					put_slot_q   <= eff_slot;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_s1 <= res_next;
			if (is_put) begin
				put_tag_q  <= eff_tag;
				put_decl_q <= eff_decl;
				if (put_close && (eff_err == STATUS_OK)) begin
					tag_q[eff_slot] <= eff_tag;
					len_q[eff_slot] <= idx_next;
				end
			end
		end
		if (cmd.load_out) begin
			rsp_q.status        <= res_s1.status;
			rsp_q.stored_length <= OUT_LEN_W'(res_s1.length);
			rsp_q.data_out      <= res_s1.rd_ok ? ram_rdata : '0;
		end
	end

	assign rsp_data = rsp_q;

	`TOS_ASSERT(a_idx_bound, put_idx_q <= LEN_W'(MAX_LEN), "put index past max length")
	`TOS_ASSERT(a_clear_empties, cmd.accept && is_clear |=> valid_q == '0, "clear left a valid slot")
	`TOS_ASSERT(a_close_ends_run, cmd.accept && is_put && put_close |=> !put_active_q, "put run not closed")
endmodule

// ===== sv/tagged_object_slot_store.sv =====
// Top level of the tagged object slot store: controller plus datapath.
// Depends on tos_pkg, tos_req_if, tos_rsp_if, tos_ctrl and tos_datapath.
//
// A table of NUM_SLOTS slots, each with a 16-bit tag, a length and up to
// MAX_LEN bytes. Requests come in on req, one transaction per item: kind 0
// is one byte of a put run (the first item carries tag and put_length and
// a run ends on last_byte, or at once when put_length is zero), kind 1 a
// get of the byte at read_offset, kind 2 clears the table and aborts any
// run, kind 3 is dropped. Only the closing put item, a get and a clear give
// a result transaction on rsp. A get during a run is served; a replaced
// tag reads as not found until its run closes. An item without a result
// is just accepted; an item with a result is first accepted (tag match
// over all slots in parallel, byte RAM read or write), and then its
// pending result moves into the output register, waiting while the
// output register is full and rsp is stalled. The next item is taken
// while a result waits in the output register. Byte storage is a
// NUM_SLOTS*MAX_LEN x 8 RAM with registered read; it needs no clearing
// after reset since a get only reads bytes the last put of that slot wrote.
module tagged_object_slot_store import tos_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	tos_req_if.sink  req,
	tos_rsp_if.source rsp
);
	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      in_ready;
	logic      out_valid;

	tos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid)
	);

	tos_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req.data),
		.stat     (stat),
		.rsp_data (rsp.data)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;
endmodule
